// ===== src/crc8fc_pkg.sv =====
// ----------------------------------------------------------------------------
// crc8fc_pkg: shared types, constants and functions of the CRC-8 frame checker
// Holds the configuration register map, the register and result structures
// and the byte-wide CRC-8 update used by the frame evaluation logic.
// ----------------------------------------------------------------------------
package crc8fc_pkg;

   // Register map of the configuration port.
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 13;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_PAYLOAD_LENGTH = 2'd0,
      CSR_CRC_POLYNOMIAL = 2'd1,
      CSR_CRC_INITIAL    = 2'd2
   } csr_index_type;

   localparam int LENGTH_WIDTH = 13;
   localparam int BYTE_WIDTH   = 8;

   // Longest payload the frame counter supports.
   localparam logic [LENGTH_WIDTH-1:0] MAX_PAYLOAD = 13'd4096;

   localparam logic [LENGTH_WIDTH-1:0] PAYLOAD_LENGTH_RESET = 13'd512;
   localparam logic [BYTE_WIDTH-1:0]   CRC_POLYNOMIAL_RESET = 8'h07;
   localparam logic [BYTE_WIDTH-1:0]   CRC_INITIAL_RESET    = 8'h00;

   typedef struct packed {
      logic [LENGTH_WIDTH-1:0] payload_length;
      logic [BYTE_WIDTH-1:0]   crc_polynomial;
      logic [BYTE_WIDTH-1:0]   crc_initial;
   } cfg_type;

   typedef struct packed {
      logic                  status;
      logic [BYTE_WIDTH-1:0] computed_crc;
      logic [BYTE_WIDTH-1:0] received_crc;
   } result_type;

   // Status codes of a frame result.
   localparam logic STATUS_GOOD     = 1'b0;
   localparam logic STATUS_MISMATCH = 1'b1;

   // One byte of CRC-8, MSB first, non-reflected.
   function automatic logic [BYTE_WIDTH-1:0] crc8_byte(
      input logic [BYTE_WIDTH-1:0] crc,
      input logic [BYTE_WIDTH-1:0] data,
      input logic [BYTE_WIDTH-1:0] poly
   );
      logic [BYTE_WIDTH-1:0] value;
      value = crc ^ data;
      for (int i = 0; i < BYTE_WIDTH; i++) begin
         if (value[BYTE_WIDTH-1]) begin
            value = {value[BYTE_WIDTH-2:0], 1'b0} ^ poly;
         end else begin
            value = {value[BYTE_WIDTH-2:0], 1'b0};
         end
      end
      return value;
   endfunction

endpackage

// ===== src/crc8fc_csr.sv =====
// ----------------------------------------------------------------------------
// crc8fc_csr: configuration registers
// Holds payload length, polynomial and initial value; writes to an unknown
// index are ignored.
// ----------------------------------------------------------------------------
module crc8fc_csr (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      csr_write_enable,
   input  logic [crc8fc_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [crc8fc_pkg::CSR_DATA_WIDTH-1:0]     csr_write_data,
   output crc8fc_pkg::cfg_type                       cfg
);

   crc8fc_pkg::cfg_type cfg_ff;
   crc8fc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            crc8fc_pkg::CSR_PAYLOAD_LENGTH: begin
               cfg_in.payload_length = csr_write_data;
            end
            crc8fc_pkg::CSR_CRC_POLYNOMIAL: begin
               cfg_in.crc_polynomial = csr_write_data[crc8fc_pkg::BYTE_WIDTH-1:0];
            end
            crc8fc_pkg::CSR_CRC_INITIAL: begin
               cfg_in.crc_initial = csr_write_data[crc8fc_pkg::BYTE_WIDTH-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.payload_length <= crc8fc_pkg::PAYLOAD_LENGTH_RESET;
         cfg_ff.crc_polynomial <= crc8fc_pkg::CRC_POLYNOMIAL_RESET;
         cfg_ff.crc_initial    <= crc8fc_pkg::CRC_INITIAL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== src/crc8fc_frame.sv =====
// ----------------------------------------------------------------------------
// crc8fc_frame: frame state and byte evaluation
// Keeps the running CRC and the byte position, decides whether the current
// byte is payload or the trailing CRC byte and forms the frame result.
// ----------------------------------------------------------------------------
module crc8fc_frame (
   input  logic                                  clock,
   input  logic                                  reset,
   input  crc8fc_pkg::cfg_type                   cfg,
   input  logic [crc8fc_pkg::BYTE_WIDTH-1:0]     data_byte,
   input  logic                                  advance,
   output logic                                  frame_end,
   output crc8fc_pkg::result_type                result
);

   logic [crc8fc_pkg::BYTE_WIDTH-1:0]   running_crc_ff;
   logic [crc8fc_pkg::BYTE_WIDTH-1:0]   running_crc_in;
   logic [crc8fc_pkg::LENGTH_WIDTH-1:0] byte_position_ff;
   logic [crc8fc_pkg::LENGTH_WIDTH-1:0] byte_position_in;
   logic [crc8fc_pkg::LENGTH_WIDTH-1:0] effective_length;
   logic [crc8fc_pkg::BYTE_WIDTH-1:0]   crc_now;

   // A length of zero counts as one; anything above the maximum saturates.
   always_comb begin
      priority if (cfg.payload_length == '0) begin
         effective_length = crc8fc_pkg::LENGTH_WIDTH'(1);
      end else if (cfg.payload_length > crc8fc_pkg::MAX_PAYLOAD) begin
         effective_length = crc8fc_pkg::MAX_PAYLOAD;
      end else begin
         effective_length = cfg.payload_length;
      end
   end

   // The first byte of a frame starts from the initial value as it is now.
   assign crc_now   = (byte_position_ff == '0) ? cfg.crc_initial : running_crc_ff;
   assign frame_end = (byte_position_ff >= effective_length);

   always_comb begin
      result.computed_crc = crc_now;
      result.received_crc = data_byte;
      result.status       = (crc_now == data_byte) ? crc8fc_pkg::STATUS_GOOD
                                                   : crc8fc_pkg::STATUS_MISMATCH;
   end

   always_comb begin
      running_crc_in   = running_crc_ff;
      byte_position_in = byte_position_ff;
      if (advance) begin
         if (frame_end) begin
            running_crc_in   = cfg.crc_initial;
            byte_position_in = '0;
         end else begin
            running_crc_in   = crc8fc_pkg::crc8_byte(crc_now, data_byte,
                                                     cfg.crc_polynomial);
            byte_position_in = byte_position_ff + crc8fc_pkg::LENGTH_WIDTH'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_crc_ff   <= crc8fc_pkg::CRC_INITIAL_RESET;
         byte_position_ff <= '0;
      end else begin
         running_crc_ff   <= running_crc_in;
         byte_position_ff <= byte_position_in;
      end
   end

endmodule

// ===== src/crc8_frame_checker.sv =====
// ----------------------------------------------------------------------------
// crc8_frame_checker: CRC-8 check of received frames
// Takes frames one byte per transfer and reports one result per frame.
// ----------------------------------------------------------------------------
// A frame is payload_length payload bytes followed by one CRC byte. The CRC-8
// runs over the payload only, MSB first and non-reflected, with the
// programmed polynomial (implicit top bit) and starts from crc_initial at the
// first byte of every frame. Payload bytes produce no result; the trailing
// byte produces exactly one, carrying status 0 when it equals the computed
// CRC and 1 otherwise, plus both CRC values. A payload_length of zero acts as
// one and values above 4096 act as 4096. The block takes one byte in every
// clock cycle unless a CRC byte waits on a stalled result. Each transfer is
// registered in the input register, evaluated there by a single unrolled
// eight-bit CRC update, and a frame result is registered in the output
// register that drives the rsp_ ports. A waiting result there does not hold
// up payload bytes. Configuration is to be written by the user only while no
// transfer is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module crc8_frame_checker (
   input  logic                                      clock,
   input  logic                                      reset,
   // Configuration write port.
   input  logic                                      csr_write_enable,
   input  logic [crc8fc_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [crc8fc_pkg::CSR_DATA_WIDTH-1:0]     csr_write_data,
   // Byte input channel.
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  logic [crc8fc_pkg::BYTE_WIDTH-1:0]         req_data_byte,
   // Frame result channel.
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output logic                                      rsp_status,
   output logic [crc8fc_pkg::BYTE_WIDTH-1:0]         rsp_computed_crc,
   output logic [crc8fc_pkg::BYTE_WIDTH-1:0]         rsp_received_crc
);

   crc8fc_pkg::cfg_type    cfg;
   crc8fc_pkg::result_type frame_result;

   logic                              in_valid_ff;
   logic                              in_valid_in;
   logic [crc8fc_pkg::BYTE_WIDTH-1:0] in_data_ff;
   logic [crc8fc_pkg::BYTE_WIDTH-1:0] in_data_in;

   logic                              rsp_valid_ff;
   logic                              rsp_valid_in;
   crc8fc_pkg::result_type            rsp_data_ff;
   crc8fc_pkg::result_type            rsp_data_in;

   logic req_transfer;
   logic rsp_free;
   logic frame_end;
   logic advance;

   crc8fc_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   crc8fc_frame u_frame (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .data_byte (in_data_ff),
      .advance   (advance),
      .frame_end (frame_end),
      .result    (frame_result)
   );

   // The output register can take a result when it is empty or being drained
   // in this cycle. Payload bytes move on regardless, since they yield nothing.
   assign rsp_free     = !rsp_valid_ff || !rsp_stall;
   assign advance      = in_valid_ff && (!frame_end || rsp_free);
   assign req_stall    = in_valid_ff && !advance;
   assign req_transfer = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      if (req_transfer) begin
         in_valid_in = 1'b1;
         in_data_in  = req_data_byte;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (advance && frame_end) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = frame_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset; their valid flags qualify them.
   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_data_ff.status;
   assign rsp_computed_crc = rsp_data_ff.computed_crc;
   assign rsp_received_crc = rsp_data_ff.received_crc;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the CRC-8 frame checker
// Streams frames through the byte channel with random gaps and result stalls,
// reprograms the registers between phases and predicts every frame result
// from a shadow copy of the registers and the frame state.
// ----------------------------------------------------------------------------
module tb_top;

   // Cycles allowed after the last expected result before the block counts as
   // idle. A payload byte causes no result, so it may still sit in the
   // pipeline when the last result has come.
   localparam int SETTLE_CYCLES = 6;
   // Bytes in the random part of the run.
   localparam int RANDOM_BYTES  = 1150;
   // A register index that the map leaves unused; writes to it are dropped.
   localparam logic [crc8fc_pkg::CSR_INDEX_WIDTH-1:0] CSR_UNMAPPED = 2'd3;

   // Every input of the block holds a known value from time zero.
   logic                                   clock            = 1'b0;
   logic                                   reset            = 1'b1;
   logic                                   csr_write_enable = 1'b0;
   logic [crc8fc_pkg::CSR_INDEX_WIDTH-1:0] csr_index        = '0;
   logic [crc8fc_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data   = '0;
   logic                                   req_valid        = 1'b0;
   logic                                   req_stall;
   logic [crc8fc_pkg::BYTE_WIDTH-1:0]      req_data_byte    = '0;
   logic                                   rsp_valid;
   logic                                   rsp_stall        = 1'b0;
   logic                                   rsp_status;
   logic [crc8fc_pkg::BYTE_WIDTH-1:0]      rsp_computed_crc;
   logic [crc8fc_pkg::BYTE_WIDTH-1:0]      rsp_received_crc;

   crc8_frame_checker dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_computed_crc (rsp_computed_crc),
      .rsp_received_crc (rsp_received_crc)
   );

   // Shadow of the configuration registers, starting from the reset values.
   crc8fc_pkg::cfg_type register_shadow = {crc8fc_pkg::PAYLOAD_LENGTH_RESET,
                                           crc8fc_pkg::CRC_POLYNOMIAL_RESET,
                                           crc8fc_pkg::CRC_INITIAL_RESET};

   // Frame state as the checker should hold it after the last accepted byte.
   logic [crc8fc_pkg::LENGTH_WIDTH-1:0] frame_fill  = '0;
   logic [crc8fc_pkg::BYTE_WIDTH-1:0]   running_crc = crc8fc_pkg::CRC_INITIAL_RESET;

   // Frame results predicted but not yet seen on the result channel.
   crc8fc_pkg::result_type results_due[$];

   // Bytes waiting to be offered on the input channel.
   logic [crc8fc_pkg::BYTE_WIDTH-1:0] byte_queue[$];

   // The stimulus keeps its own view of the frame position, so that it can
   // close frames with a correct or a deliberately wrong CRC byte.
   int                                gen_fill = 0;
   logic [crc8fc_pkg::BYTE_WIDTH-1:0] gen_crc  = '0;

   // Idling switches, flipped per phase so that some phases run flat out.
   bit send_idle = 1'b1;
   bit recv_idle = 1'b1;

   int mismatch_count  = 0;
   int bytes_planned   = 0;
   int bytes_sent      = 0;
   int results_checked = 0;
   int frames_good     = 0;
   int frames_bad      = 0;
   int register_writes = 0;

   int gap_left  = 0;
   int hold_left = 0;

   initial forever #2 clock = ~clock;

   // -------------------------------------------------------------------------
   // Prediction
   // -------------------------------------------------------------------------

   // CRC-8 of one byte in its bit-serial form: each data bit, MSB first, is
   // folded into the top of the register and the polynomial is applied when
   // the feedback bit is set.
   function automatic logic [crc8fc_pkg::BYTE_WIDTH-1:0] crc_shift_byte(
      input logic [crc8fc_pkg::BYTE_WIDTH-1:0] crc,
      input logic [crc8fc_pkg::BYTE_WIDTH-1:0] data,
      input logic [crc8fc_pkg::BYTE_WIDTH-1:0] poly
   );
      logic [crc8fc_pkg::BYTE_WIDTH-1:0] acc;
      logic                              feedback;
      acc = crc;
      for (int i = crc8fc_pkg::BYTE_WIDTH - 1; i >= 0; i--) begin
         feedback = acc[crc8fc_pkg::BYTE_WIDTH-1] ^ data[i];
         acc = {acc[crc8fc_pkg::BYTE_WIDTH-2:0], 1'b0} ^ (feedback ? poly : '0);
      end
      return acc;
   endfunction

   // A length of zero behaves as one and anything above the maximum is
   // clipped to the maximum.
   function automatic logic [crc8fc_pkg::LENGTH_WIDTH-1:0] effective_length(
      input logic [crc8fc_pkg::LENGTH_WIDTH-1:0] programmed
   );
      if (programmed == '0) return crc8fc_pkg::LENGTH_WIDTH'(1);
      if (programmed > crc8fc_pkg::MAX_PAYLOAD) return crc8fc_pkg::MAX_PAYLOAD;
      return programmed;
   endfunction

   // Advance the frame state by one accepted byte. Once the frame holds as
   // many payload bytes as the current length, the byte is the CRC byte; this
   // also covers a length cut below the bytes already taken.
   function automatic void predict_byte(input logic [crc8fc_pkg::BYTE_WIDTH-1:0] data);
      logic [crc8fc_pkg::BYTE_WIDTH-1:0] crc_now;
      crc8fc_pkg::result_type            due;
      crc_now = (frame_fill == '0) ? register_shadow.crc_initial : running_crc;
      if (frame_fill >= effective_length(register_shadow.payload_length)) begin
         due.status       = (crc_now == data) ? crc8fc_pkg::STATUS_GOOD
                                              : crc8fc_pkg::STATUS_MISMATCH;
         due.computed_crc = crc_now;
         due.received_crc = data;
         results_due.push_back(due);
         frame_fill  = '0;
         running_crc = register_shadow.crc_initial;
      end else begin
         running_crc = crc_shift_byte(crc_now, data, register_shadow.crc_polynomial);
         frame_fill  = frame_fill + 1'b1;
      end
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("MISMATCH at %0t ns: %s", $time, what);
   endtask

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------

   function automatic void queue_byte(input logic [crc8fc_pkg::BYTE_WIDTH-1:0] data);
      byte_queue.push_back(data);
      bytes_planned++;
   endfunction

   // Payload bytes: random when the pattern is negative, else a fixed value.
   function automatic void queue_payload(input int count, input int pattern);
      logic [crc8fc_pkg::BYTE_WIDTH-1:0] data;
      for (int k = 0; k < count; k++) begin
         data = (pattern < 0) ? crc8fc_pkg::BYTE_WIDTH'($urandom)
                              : crc8fc_pkg::BYTE_WIDTH'(pattern);
         gen_crc = crc_shift_byte((gen_fill == 0) ? register_shadow.crc_initial : gen_crc,
                                  data, register_shadow.crc_polynomial);
         gen_fill++;
         queue_byte(data);
      end
   endfunction

   // Fill the current frame up to the programmed length and close it. A bad
   // CRC byte differs from the right one in at least one bit.
   function automatic void queue_frame(input bit crc_good, input int pattern);
      int left;
      left = int'(effective_length(register_shadow.payload_length)) - gen_fill;
      if (left > 0) queue_payload(left, pattern);
      queue_byte(crc_good ? gen_crc
                          : gen_crc ^ crc8fc_pkg::BYTE_WIDTH'($urandom_range(1, 255)));
      gen_fill = 0;
   endfunction

   // Take over the predicted frame position once the block has gone idle.
   task automatic resync();
      @(negedge clock);
      gen_fill = int'(frame_fill);
      gen_crc  = running_crc;
   endtask

   // Hold off until every queued byte has been transferred, every predicted
   // result has come back and the pipeline has had time to empty.
   task automatic wait_for_idle();
      do @(negedge clock);
      while (byte_queue.size() != 0 || req_valid || results_due.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // The write enable stays high across back-to-back writes and is lowered by
   // end_writes, so it never drops and rises within one time step.
   task automatic write_register(input logic [crc8fc_pkg::CSR_INDEX_WIDTH-1:0] index,
                                 input logic [crc8fc_pkg::CSR_DATA_WIDTH-1:0]  value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value;
      case (index)
         crc8fc_pkg::CSR_PAYLOAD_LENGTH:
            register_shadow.payload_length = value;
         crc8fc_pkg::CSR_CRC_POLYNOMIAL:
            register_shadow.crc_polynomial = value[crc8fc_pkg::BYTE_WIDTH-1:0];
         crc8fc_pkg::CSR_CRC_INITIAL:
            register_shadow.crc_initial    = value[crc8fc_pkg::BYTE_WIDTH-1:0];
         default: ;
      endcase
      register_writes++;
   endtask

   task automatic end_writes();
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [crc8fc_pkg::CSR_INDEX_WIDTH-1:0] random_register();
      case ($urandom_range(0, 3))
         0:       return crc8fc_pkg::CSR_PAYLOAD_LENGTH;
         1:       return crc8fc_pkg::CSR_CRC_POLYNOMIAL;
         2:       return crc8fc_pkg::CSR_CRC_INITIAL;
         default: return CSR_UNMAPPED;
      endcase
   endfunction

   // Random lengths stay short so that many frames close; the byte registers
   // get all thirteen data bits at random, the upper ones being ignored.
   function automatic logic [crc8fc_pkg::CSR_DATA_WIDTH-1:0] random_setting(
      input logic [crc8fc_pkg::CSR_INDEX_WIDTH-1:0] index
   );
      int pick;
      pick = $urandom_range(0, 99);
      if (index != crc8fc_pkg::CSR_PAYLOAD_LENGTH) begin
         return crc8fc_pkg::CSR_DATA_WIDTH'($urandom);
      end
      if (pick < 10) return '0;
      if (pick < 70) return crc8fc_pkg::CSR_DATA_WIDTH'($urandom_range(1, 6));
      if (pick < 92) return crc8fc_pkg::CSR_DATA_WIDTH'($urandom_range(7, 24));
      return crc8fc_pkg::CSR_DATA_WIDTH'($urandom_range(25, 64));
   endfunction

   // Mostly short pauses, now and then a long one.
   function automatic int pause_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) return $urandom_range(1, 2);
      if (pick < 95) return $urandom_range(3, 8);
      return $urandom_range(16, 40);
   endfunction

   // -------------------------------------------------------------------------
   // Byte driver: offers the queued bytes one transfer at a time. A stalled
   // byte is held unchanged; after each byte a random gap may follow.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left  <= 0;
      end else if (req_valid && req_stall) begin
         // Stalled: the byte stays on the port as it is.
      end else if (gap_left > 0) begin
         req_valid <= 1'b0;
         gap_left  <= gap_left - 1;
      end else if (byte_queue.size() != 0) begin
         req_valid     <= 1'b1;
         req_data_byte <= byte_queue.pop_front();
         gap_left      <= (send_idle && $urandom_range(0, 2) == 0) ? pause_length() : 0;
      end else begin
         req_valid <= 1'b0;
      end
   end

   // -------------------------------------------------------------------------
   // Result receiver: stalls the result channel in bursts of random length.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (recv_idle && $urandom_range(0, 3) == 0) begin
         rsp_stall <= 1'b1;
         hold_left <= pause_length() - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // -------------------------------------------------------------------------
   // Monitor: watches both channels at the clock edge. An input transfer is
   // turned into a prediction first, so a result in the same edge would still
   // find its expectation; each result transfer is then compared with the
   // oldest expectation.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      crc8fc_pkg::result_type due;
      if (reset) begin
         frame_fill  = '0;
         running_crc = register_shadow.crc_initial;
      end else begin
         if (req_valid && !req_stall) begin
            predict_byte(req_data_byte);
            bytes_sent++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (results_due.size() == 0) begin
               report_mismatch($sformatf(
                  "result with no frame closed: status %0b computed %02h received %02h",
                  rsp_status, rsp_computed_crc, rsp_received_crc));
            end else begin
               due = results_due.pop_front();
               results_checked++;
               if (due.status == crc8fc_pkg::STATUS_GOOD) frames_good++;
               else frames_bad++;
               if (rsp_status !== due.status) begin
                  report_mismatch($sformatf("status %0b, expected %0b",
                                            rsp_status, due.status));
               end
               if (rsp_computed_crc !== due.computed_crc) begin
                  report_mismatch($sformatf("computed CRC %02h, expected %02h",
                                            rsp_computed_crc, due.computed_crc));
               end
               if (rsp_received_crc !== due.received_crc) begin
                  report_mismatch($sformatf("received CRC %02h, expected %02h",
                                            rsp_received_crc, due.received_crc));
               end
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus: a directed part, then random phases. Between phases the sender
   // waits until every expected result has come back, and only then are the
   // registers rewritten, often in the middle of a frame.
   // -------------------------------------------------------------------------
   initial begin : stimulus
      int                                     random_start;
      int                                     writes;
      int                                     frames;
      logic [crc8fc_pkg::CSR_INDEX_WIDTH-1:0] target;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      resync();

      // Reset values: three payload bytes under the default polynomial and
      // initial value, then the length is cut below the bytes already taken,
      // so the next byte is treated as the CRC byte.
      queue_payload(3, 'hA5);
      wait_for_idle();
      write_register(crc8fc_pkg::CSR_PAYLOAD_LENGTH, 13'd2);
      end_writes();
      resync();
      queue_frame(1'b1, -1);
      wait_for_idle();

      // Zero length acts as one; polynomial and initial value all ones, with
      // the unused upper data bits set as well.
      write_register(crc8fc_pkg::CSR_PAYLOAD_LENGTH, '0);
      write_register(crc8fc_pkg::CSR_CRC_POLYNOMIAL, 13'h1FFF);
      write_register(crc8fc_pkg::CSR_CRC_INITIAL, 13'h1FFF);
      end_writes();
      resync();
      queue_frame(1'b1, 'h00);
      queue_frame(1'b0, 'hFF);
      wait_for_idle();

      // Zero polynomial and initial value.
      write_register(crc8fc_pkg::CSR_CRC_POLYNOMIAL, '0);
      write_register(crc8fc_pkg::CSR_CRC_INITIAL, '0);
      write_register(crc8fc_pkg::CSR_PAYLOAD_LENGTH, 13'd1);
      end_writes();
      resync();
      queue_frame(1'b1, 'hFF);
      queue_frame(1'b0, -1);
      wait_for_idle();

      // Polynomial and initial value rewritten half-way through a frame: the
      // new polynomial applies at once, the new initial value only from the
      // next frame on.
      write_register(crc8fc_pkg::CSR_PAYLOAD_LENGTH, 13'd4);
      write_register(crc8fc_pkg::CSR_CRC_POLYNOMIAL, 13'h031);
      end_writes();
      resync();
      queue_payload(2, -1);
      wait_for_idle();
      write_register(crc8fc_pkg::CSR_CRC_POLYNOMIAL, 13'h09B);
      write_register(crc8fc_pkg::CSR_CRC_INITIAL, 13'h05A);
      end_writes();
      resync();
      queue_frame(1'b1, -1);
      queue_frame(1'b1, -1);
      wait_for_idle();

      // A write to the unused index must leave every register alone.
      write_register(CSR_UNMAPPED, 13'h1FFF);
      end_writes();
      resync();
      queue_frame(1'b1, -1);
      wait_for_idle();

      // Largest length field: a few payload bytes do not close the frame,
      // which is then closed by cutting the length to the bytes taken.
      write_register(crc8fc_pkg::CSR_PAYLOAD_LENGTH, 13'h1FFF);
      end_writes();
      resync();
      queue_payload(5, -1);
      wait_for_idle();
      write_register(crc8fc_pkg::CSR_PAYLOAD_LENGTH, 13'd5);
      end_writes();
      resync();
      queue_frame(1'b1, -1);
      wait_for_idle();

      // Exactly the maximum, then cut to the number of bytes already taken.
      write_register(crc8fc_pkg::CSR_PAYLOAD_LENGTH, crc8fc_pkg::MAX_PAYLOAD);
      end_writes();
      resync();
      queue_payload(3, -1);
      wait_for_idle();
      write_register(crc8fc_pkg::CSR_PAYLOAD_LENGTH, 13'd3);
      end_writes();
      resync();
      queue_frame(1'b0, -1);

      // Random phases: a few register writes, then well-formed frames with
      // random content and mostly correct CRC bytes, sometimes followed by a
      // frame broken off part-way that the next phase finishes.
      random_start = bytes_planned;
      while (bytes_planned - random_start < RANDOM_BYTES) begin
         wait_for_idle();
         send_idle = ($urandom_range(0, 3) != 0);
         recv_idle = ($urandom_range(0, 3) != 0);
         writes = $urandom_range(0, 3);
         for (int w = 0; w < writes; w++) begin
            target = random_register();
            write_register(target, random_setting(target));
         end
         if (writes != 0) end_writes();
         resync();
         frames = $urandom_range(1, 8);
         for (int f = 0; f < frames; f++) begin
            queue_frame($urandom_range(0, 3) != 0, -1);
         end
         if ($urandom_range(0, 3) == 0) begin
            queue_payload($urandom_range(1,
               int'(effective_length(register_shadow.payload_length))), -1);
         end
      end

      wait_for_idle();
      $display("Checked %0d frame results (%0d good CRC, %0d mismatching) from %0d bytes,",
               results_checked, frames_good, frames_bad, bytes_sent);
      $display("with %0d register writes, lengths from zero to beyond the maximum.",
               register_writes);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Upper bound on the run: several times the slowest correct run, with
   // long gaps before every byte and long stalls throughout.
   initial begin : watchdog
      #3_500_000;
      $display("Timed out with %0d bytes queued and %0d results outstanding.",
               byte_queue.size(), results_due.size());
      $display("end of test: mismatches");
      $finish;
   end

endmodule
